// ===== rtl/cbz_pkg.sv =====
package cbz_pkg;

   // Default widths: pixel coordinates and the fraction bits of t.
   localparam int COORD_BITS_DEF  = 10;
   localparam int T_FRAC_BITS_DEF = 12;

   // Control point registers: four points, two coordinates each.
   localparam int NUM_POINTS    = 4;
   localparam int NUM_AXES      = 2;
   localparam int NUM_REGS      = NUM_POINTS * NUM_AXES;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = $clog2(NUM_REGS * 4);

   // Coordinate selectors within a point.
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;

endpackage

// ===== rtl/cbz_req_if.sv =====
interface cbz_req_if import cbz_pkg::*; #(
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [T_FRAC_BITS:0] t_frac;

   modport source (output valid, output t_frac, input ready);
   modport sink   (input valid, input t_frac, output ready);
endinterface

// ===== rtl/cbz_rsp_if.sv =====
interface cbz_rsp_if import cbz_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/cubic_bezier_point_eval.sv =====
// Cubic Bezier point evaluator, de Casteljau form, exact fixed point.
// Four registered stages: clamp, then three lerp levels; the last drives rsp.
// Throughput: one item per cycle while rsp is ready, else the stages hold.
// Each stage holds under backpressure and fills its bubbles independently.
// Reset (synchronous, active high) clears all valid bits and the control points.
module cubic_bezier_point_eval import cbz_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   // item channels
   cbz_req_if.sink                  req,
   cbz_rsp_if.source                rsp
);

   // Widths of the de Casteljau levels. Each level lerps with weights s and t
   // that sum to 2^T_FRAC_BITS, so each level grows by T_FRAC_BITS bits and
   // stays exact; the final floor is a plain bit select.
   localparam int CW = COORD_BITS;
   localparam int TW = T_FRAC_BITS;
   localparam int QW = CW + TW;        // level 1, scale 2^TW
   localparam int RW = CW + 2 * TW;    // level 2, scale 2^(2*TW)
   localparam int FW = CW + 3 * TW;    // level 3, scale 2^(3*TW)

   localparam logic [TW:0] T_ONE = {1'b1, {TW{1'b0}}};

   // ------------------------------------------------------------------
   // Control point registers
   // ------------------------------------------------------------------
   logic [CW-1:0] point_ff [NUM_POINTS][NUM_AXES];

   logic                          csr_write;
   logic [$clog2(NUM_REGS)-1:0]   csr_index;
   logic [$clog2(NUM_POINTS)-1:0] csr_point;
   logic                          csr_axis;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   // Register order is x then y for each point in turn.
   assign csr_point  = csr_index[$clog2(NUM_REGS)-1:1];
   assign csr_axis   = csr_index[0];
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_BITS'(point_ff[csr_point][csr_axis]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_POINTS; p++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               point_ff[p][a] <= '0;
            end
         end
      end else if (csr_write) begin
         // Keep only the coordinate bits of the written word.
         point_ff[csr_point][csr_axis] <= csr_pwdata[CW-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or when the
   // stage after it loads this cycle, or for the last stage when rsp is ready.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic load1, load2, load3, load4;

   assign load4     = !v4_ff || rsp.ready;
   assign load3     = !v3_ff || load4;
   assign load2     = !v2_ff || load3;
   assign load1     = !v1_ff || load2;
   assign req.ready = load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= req.valid;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
         if (load4) v4_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: clamp t to one and form s = 1 - t
   // ------------------------------------------------------------------
   logic [TW:0] t1_in, s1_in;
   logic [TW:0] t1_ff, s1_ff;

   always_comb begin
      t1_in = (req.t_frac > T_ONE) ? T_ONE : req.t_frac;
      s1_in = T_ONE - t1_in;
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         t1_ff <= t1_in;
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: first lerp level, three points per axis
   // ------------------------------------------------------------------
   logic [QW:0]   q_sum [NUM_AXES][3];
   logic [QW-1:0] q_ff  [NUM_AXES][3];
   logic [TW:0]   t2_ff, s2_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int i = 0; i < 3; i++) begin
            q_sum[a][i] = (QW+1)'(s1_ff) * (QW+1)'(point_ff[i][a])
                        + (QW+1)'(t1_ff) * (QW+1)'(point_ff[i+1][a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            for (int i = 0; i < 3; i++) begin
               q_ff[a][i] <= q_sum[a][i][QW-1:0];
            end
         end
         t2_ff <= t1_ff;
         s2_ff <= s1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: second lerp level, two points per axis
   // ------------------------------------------------------------------
   logic [RW:0]   r_sum [NUM_AXES][2];
   logic [RW-1:0] r_ff  [NUM_AXES][2];
   logic [TW:0]   t3_ff, s3_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int j = 0; j < 2; j++) begin
            r_sum[a][j] = (RW+1)'(s2_ff) * (RW+1)'(q_ff[a][j])
                        + (RW+1)'(t2_ff) * (RW+1)'(q_ff[a][j+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            for (int j = 0; j < 2; j++) begin
               r_ff[a][j] <= r_sum[a][j][RW-1:0];
            end
         end
         t3_ff <= t2_ff;
         s3_ff <= s2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: last lerp level and floor; this is the output register
   // ------------------------------------------------------------------
   logic [FW:0]   f_sum [NUM_AXES];
   logic [CW-1:0] pix_ff [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         f_sum[a] = (FW+1)'(s3_ff) * (FW+1)'(r_ff[a][0])
                  + (FW+1)'(t3_ff) * (FW+1)'(r_ff[a][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            // Drop the 3*TW fraction bits: exact floor of the curve point.
            pix_ff[a] <= f_sum[a][3*TW +: CW];
         end
      end
   end

   assign rsp.valid   = v4_ff;
   assign rsp.pixel_x = pix_ff[AXIS_X];
   assign rsp.pixel_y = pix_ff[AXIS_Y];

endmodule
